/* rtl/bubble_point_transform_assert.svh */
// ----------------------------------------------------------------------------
// Bubble point transform assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BUBBLE_POINT_TRANSFORM_ASSERT_SVH
`define BUBBLE_POINT_TRANSFORM_ASSERT_SVH

// Same-cycle implication.
`define BPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bpt_pkg.sv */
// ----------------------------------------------------------------------------
// Bubble point transform package
// Shared widths, register codes, stage payload types and saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bpt_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_WEIGHT   = 2'd0,
    CFG_CENTER_X = 2'd1,
    CFG_CENTER_Y = 2'd2,
    CFG_SCALE    = 2'd3
  } cfg_idx_t;

  localparam int W_W     = 21;   // weight width
  localparam int C_W     = 24;   // center and scale width
  localparam int Q_W     = 29;   // quotient k magnitude width (Q5.24)
  localparam int DIV_STEPS = Q_W;
  localparam int SAT_W   = 49;   // width of pre-saturation sums
  localparam int RECIP_STEPS = 33;  // dividend 2^32 has 33 bits
  localparam int IN_W    = 160;
  localparam int OUT_W   = 120;

  localparam logic [31:0] RECIP_RESET = 32'h0001_0000;
  localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN     = 32'h8000_0000;

  // Live configuration handed to the datapath.
  typedef struct packed {
    logic [W_W-1:0] weight;
    logic [C_W-1:0] center_x;
    logic [C_W-1:0] center_y;
    logic [31:0]    recip_mag;
    logic           busy;
  } cfg_t;

  // Fields that ride along the divider.
  typedef struct packed {
    logic [31:0] mx;
    logic [31:0] my;
    logic        xneg;
    logic        yneg;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] nz;
    logic        ovz;
  } div_side_t;

  // Saturated point and overflow flag.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        ov;
  } res_t;

  // Saturate a two's complement sum to 32 bits; bit 32 flags saturation.
  function automatic logic [32:0] sat_q16(input logic [SAT_W-1:0] v);
    logic [32:0] res;
    if ((&v[SAT_W-1:31]) || (~|v[SAT_W-1:31])) begin
      res = {1'b0, v[31:0]};
    end else if (v[SAT_W-1]) begin
      res = {1'b1, NEG_MIN};
    end else begin
      res = {1'b1, POS_MAX};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/bpt_cfg.sv */
// ----------------------------------------------------------------------------
// Bubble point transform configuration
// Holds the registers and computes the color scale reciprocal bit-serially.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpt_cfg
  import bpt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_idx,
  input  wire logic [C_W-1:0]  cfg_data,
  output cfg_t                 cfg
);

  logic [W_W-1:0] weight_r;
  logic [C_W-1:0] cx_r;
  logic [C_W-1:0] cy_r;
  logic [31:0]    recip_r;
  logic           busy_r;
  logic           sneg_r;
  logic [5:0]     cnt_r;
  logic [23:0]    dvs_r;
  logic [23:0]    rem_r;
  logic [32:0]    quo_r;

  logic [23:0] smag;
  logic [24:0] rem2;
  logic        ge;
  logic [23:0] rem_nxt;
  logic [32:0] quo_nxt;

  // Magnitude of the written scale and one restoring step.
  always_comb begin
    smag    = cfg_data[C_W-1] ? (24'd0 - cfg_data) : cfg_data;
    rem2    = {rem_r, (cnt_r == 6'(RECIP_STEPS))};
    ge      = rem2 >= {1'b0, dvs_r};
    rem_nxt = ge ? 24'(rem2 - {1'b0, dvs_r}) : rem2[23:0];
    quo_nxt = {quo_r[31:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= W_W'(32'h0001_0000);
      cx_r     <= '0;
      cy_r     <= '0;
      recip_r  <= RECIP_RESET;
      busy_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_WEIGHT:   weight_r <= cfg_data[W_W-1:0];
          CFG_CENTER_X: cx_r <= cfg_data;
          CFG_CENTER_Y: cy_r <= cfg_data;
          CFG_SCALE: begin
            // A zero scale stands for 1e-5, whose reciprocal saturates.
            if (cfg_data == '0) begin
              recip_r <= POS_MAX;
              busy_r  <= 1'b0;
            end else begin
              busy_r <= 1'b1;
              cnt_r  <= 6'(RECIP_STEPS);
            end
          end
          default: ;
        endcase
      end
      // The reciprocal keeps running across writes of the other registers.
      if (busy_r && !(cfg_we && (cfg_idx_t'(cfg_idx) == CFG_SCALE))) begin
        if (cnt_r == '0) begin
          // Saturate the quotient magnitude per the sign of the scale.
          busy_r <= 1'b0;
          if (!sneg_r) begin
            recip_r <= (quo_r > {1'b0, POS_MAX}) ? POS_MAX : quo_r[31:0];
          end else begin
            recip_r <= (quo_r > {1'b0, NEG_MIN}) ? NEG_MIN : quo_r[31:0];
          end
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (cfg_we && (cfg_idx_t'(cfg_idx) == CFG_SCALE)) begin
      sneg_r <= cfg_data[C_W-1];
      dvs_r  <= smag;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r && (cnt_r != '0)) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign cfg = '{weight: weight_r, center_x: cx_r, center_y: cy_r,
                 recip_mag: recip_r, busy: busy_r};

endmodule
`default_nettype wire

/* rtl/bpt_kdiv.sv */
// ----------------------------------------------------------------------------
// Bubble point transform k divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpt_kdiv
  import bpt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire logic [63:0] in_rem,
  input  wire logic [63:0] in_den,
  input  wire div_side_t   in_side,
  output logic             out_vld,
  output logic [Q_W-1:0]   out_quo,
  output div_side_t        out_side
);

  logic            vld_r  [DIV_STEPS];
  logic [63:0]     rem_r  [DIV_STEPS];
  logic [63:0]     den_r  [DIV_STEPS];
  logic [Q_W-1:0]  quo_r  [DIV_STEPS];
  div_side_t       side_r [DIV_STEPS];

  logic            lk_vld  [DIV_STEPS+1];
  logic [63:0]     lk_rem  [DIV_STEPS+1];
  logic [63:0]     lk_den  [DIV_STEPS+1];
  logic [Q_W-1:0]  lk_quo  [DIV_STEPS+1];
  div_side_t       lk_side [DIV_STEPS+1];

  assign lk_vld[0]  = in_vld;
  assign lk_rem[0]  = in_rem;
  assign lk_den[0]  = in_den;
  assign lk_quo[0]  = '0;
  assign lk_side[0] = in_side;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic [64:0] rem2;
    logic        ge;

    // Shift the remainder and try to subtract the divisor.
    always_comb begin
      rem2 = {lk_rem[g], 1'b0};
      ge   = rem2 >= {1'b0, lk_den[g]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= lk_vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? 64'(rem2 - {1'b0, lk_den[g]}) : rem2[63:0];
        den_r[g]  <= lk_den[g];
        quo_r[g]  <= {lk_quo[g][Q_W-2:0], ge};
        side_r[g] <= lk_side[g];
      end
    end

    assign lk_vld[g+1]  = vld_r[g];
    assign lk_rem[g+1]  = rem_r[g];
    assign lk_den[g+1]  = den_r[g];
    assign lk_quo[g+1]  = quo_r[g];
    assign lk_side[g+1] = side_r[g];
  end

  assign out_vld  = lk_vld[DIV_STEPS];
  assign out_quo  = lk_quo[DIV_STEPS];
  assign out_side = lk_side[DIV_STEPS];

endmodule
`default_nettype wire

/* rtl/bpt_color.sv */
// ----------------------------------------------------------------------------
// Bubble point transform color
// Five-stage pipeline for the scaled squared distance fraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpt_color
  import bpt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire cfg_t        cfg,
  input  wire logic        in_vld,
  input  wire res_t        in_res,
  output logic             out_vld,
  output res_t             out_res,
  output logic [15:0]      out_color
);

  logic [4:0]  vld_r;
  res_t        res1_r, res2_r, res3_r, res4_r, res5_r;
  logic [31:0] ma_r, mb_r;
  logic [63:0] sqa_r, sqb_r;
  logic [47:0] sum_r;
  logic [55:0] plo_r;
  logic [23:0] phi_r;
  logic [15:0] color_r;

  logic [32:0] ea, eb;
  logic [32:0] na, nb;
  logic [55:0] phi_full;
  logic [47:0] fin;

  // Offsets from the center, in 33 bits.
  always_comb begin
    ea = {in_res.x[31], in_res.x} + {{9{cfg.center_x[C_W-1]}}, cfg.center_x};
    eb = {in_res.y[31], in_res.y} + {{9{cfg.center_y[C_W-1]}}, cfg.center_y};
    na = 33'd0 - ea;
    nb = 33'd0 - eb;
    phi_full = cfg.recip_mag * sum_r[47:24];
    fin = plo_r[47:0] + {phi_r, 24'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Magnitudes.
      ma_r   <= ea[32] ? na[31:0] : ea[31:0];
      mb_r   <= eb[32] ? nb[31:0] : eb[31:0];
      res1_r <= in_res;
      // Squares.
      sqa_r  <= ma_r * ma_r;
      sqb_r  <= mb_r * mb_r;
      res2_r <= res1_r;
      // Only the low 48 bits reach the fraction.
      sum_r  <= sqa_r[47:0] + sqb_r[47:0];
      res3_r <= res2_r;
      // Split product, low and high halves of the sum.
      plo_r  <= cfg.recip_mag * sum_r[23:0];
      phi_r  <= phi_full[23:0];
      res4_r <= res3_r;
      // Fraction bits.
      color_r <= fin[47:32];
      res5_r  <= res4_r;
    end
  end

  assign out_vld   = vld_r[4];
  assign out_res   = res5_r;
  assign out_color = color_r;

endmodule
`default_nettype wire

/* rtl/bpt_skid.sv */
// ----------------------------------------------------------------------------
// Bubble point transform output skid buffer
// Output register plus one spare entry; its ready is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpt_skid
  import bpt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  input  wire logic [OUT_W-1:0] up_data,
  output logic                  up_ready,
  output logic                  dn_valid,
  output logic [OUT_W-1:0]      dn_data,
  input  wire logic             dn_ready
);

  logic             out_vld_r, skid_vld_r;
  logic [OUT_W-1:0] out_dat_r, skid_dat_r;
  logic             push, load;

  assign up_ready = !skid_vld_r;
  assign push     = up_valid && up_ready;
  assign load     = dn_ready || !out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r  <= skid_vld_r || push;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_dat_r <= skid_vld_r ? skid_dat_r : up_data;
    end else if (push) begin
      skid_dat_r <= up_data;
    end
  end

  assign dn_valid = out_vld_r;
  assign dn_data  = out_dat_r;

endmodule
`default_nettype wire

/* rtl/bubble_point_transform.sv */
// ----------------------------------------------------------------------------
// Bubble point transform
// Bubble variation of a flame point in Q16.16 with saturation and color.
//
//   Channel   Direction  Beat contents
//   in_*      input      src_x, src_y, acc_x, acc_y, acc_z
//   out_*     output     out_x, out_y, out_z, color, overflow
//   cfg_*     input      write of weight, center_x, center_y or scale
//
// One beat is accepted per cycle while in_tready is high.
// The depth comes from the 29-stage divider for k plus multiply and color stages.
// A nonzero scale write runs a bit-serial reciprocal; in_tready is low then.
// A stall at the output freezes the pipeline once the skid entry is full.
// Reset is synchronous and active low; it clears valid bits and resets the config registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bubble_point_transform_assert.svh"
module bubble_point_transform
  import bpt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // src_x, src_y, acc_x, acc_y, acc_z (32 bits each), from bit 0 up
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // out_x, out_y, out_z (32 each), color (16), overflow (1), zero pad, from bit 0 up
  output logic [OUT_W-1:0]      out_tdata,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_idx,
  input  wire logic [C_W-1:0]   cfg_data
);

  cfg_t        cfg;
  logic        en;

  logic        v1_r, v2_r, vm_r, va_r;
  logic [63:0] sqx_r, sqy_r;
  logic [31:0] mx1_r, my1_r, px1_r, py1_r, pz1_r;
  logic        xn1_r, yn1_r;
  logic [63:0] rem2_r, den2_r;
  div_side_t   side2_r;

  logic [31:0] x, y, mx, my;
  logic [63:0] rsum;
  logic [SAT_W-1:0] zsum;
  logic [32:0] zsat;
  logic [W_W-1:0] wmag;

  logic            dv_vld;
  logic [Q_W-1:0]  dv_quo;
  div_side_t       dv_side;

  logic [60:0] pkx_r, pky_r;
  logic        negx_r, negy_r;
  div_side_t   sidem_r;
  logic [38:0] tx, ty;
  logic [SAT_W-1:0] xsum, ysum;
  logic [32:0] xsat, ysat;
  res_t        resa_r;

  logic        c_vld;
  res_t        c_res;
  logic [15:0] c_color;
  logic        sk_ready;

  bpt_cfg u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .cfg
  );

  assign en        = sk_ready;
  assign in_tready = en && !cfg.busy;

  // Magnitudes of the source point.
  always_comb begin
    x  = in_tdata[31:0];
    y  = in_tdata[63:32];
    mx = x[31] ? (32'd0 - x) : x;
    my = y[31] ? (32'd0 - y) : y;
    wmag = cfg.weight[W_W-1] ? (W_W'(0) - cfg.weight) : cfg.weight;
  end

  // Stage 1: squares.
  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= mx * mx;
      sqy_r <= my * my;
      mx1_r <= mx;
      my1_r <= my;
      xn1_r <= x[31];
      yn1_r <= y[31];
      px1_r <= in_tdata[95:64];
      py1_r <= in_tdata[127:96];
      pz1_r <= in_tdata[159:128];
    end
  end

  // Stage 2: radius, divider operands and the z result.
  always_comb begin
    rsum = sqx_r + sqy_r;
    zsum = {{16{pz1_r[31]}}, pz1_r, 1'b0} + {2'b00, rsum[63:17]}
         + SAT_W'(131072) - {{(SAT_W-W_W){cfg.weight[W_W-1]}}, cfg.weight};
    zsat = sat_q16(zsum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem2_r  <= {30'd0, wmag, 13'd0};
      den2_r  <= rsum + 64'h0000_0004_0000_0000;
      side2_r <= '{mx: mx1_r, my: my1_r, xneg: xn1_r, yneg: yn1_r,
                   px: px1_r, py: py1_r, nz: zsat[31:0], ovz: zsat[32]};
    end
  end

  bpt_kdiv u_kdiv (
    .clk, .rst_n, .en,
    .in_vld (v2_r), .in_rem (rem2_r), .in_den (den2_r), .in_side (side2_r),
    .out_vld (dv_vld), .out_quo (dv_quo), .out_side (dv_side)
  );

  // Multiply stage: k times the source coordinates.
  always_ff @(posedge clk) begin
    if (en) begin
      pkx_r   <= dv_quo * dv_side.mx;
      pky_r   <= dv_quo * dv_side.my;
      negx_r  <= cfg.weight[W_W-1] ^ dv_side.xneg;
      negy_r  <= cfg.weight[W_W-1] ^ dv_side.yneg;
      sidem_r <= dv_side;
    end
  end

  // Add stage: doubled accumulator plus the truncated products.
  always_comb begin
    tx   = negx_r ? (39'd0 - {2'b00, pkx_r[60:24]}) : {2'b00, pkx_r[60:24]};
    ty   = negy_r ? (39'd0 - {2'b00, pky_r[60:24]}) : {2'b00, pky_r[60:24]};
    xsum = {{16{sidem_r.px[31]}}, sidem_r.px, 1'b0} + {{10{tx[38]}}, tx};
    ysum = {{16{sidem_r.py[31]}}, sidem_r.py, 1'b0} + {{10{ty[38]}}, ty};
    xsat = sat_q16(xsum);
    ysat = sat_q16(ysum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      resa_r <= '{x: xsat[31:0], y: ysat[31:0], z: sidem_r.nz,
                  ov: xsat[32] | ysat[32] | sidem_r.ovz};
    end
  end

  // Valid bits of the stages in this file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vm_r <= 1'b0;
      va_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid && !cfg.busy;
      v2_r <= v1_r;
      vm_r <= dv_vld;
      va_r <= vm_r;
    end
  end

  bpt_color u_color (
    .clk, .rst_n, .en, .cfg,
    .in_vld (va_r), .in_res (resa_r),
    .out_vld (c_vld), .out_res (c_res), .out_color (c_color)
  );

  bpt_skid u_skid (
    .clk, .rst_n,
    .up_valid (c_vld),
    .up_data  ({7'd0, c_res.ov, c_color, c_res.z, c_res.y, c_res.x}),
    .up_ready (sk_ready),
    .dn_valid (out_tvalid),
    .dn_data  (out_tdata),
    .dn_ready (out_tready)
  );

  // A reciprocal run starts only from a scale write.
  `BPT_ASSERT_IMP(a_busy_from_write, $rose(cfg.busy),
    $past(cfg_we) && ($past(cfg_idx) == CFG_SCALE), "reciprocal started without scale write")

  // No beat enters while the reciprocal is being formed.
  `BPT_ASSERT_NXT(a_no_entry_busy, cfg.busy, !v1_r || !$past(en),
    "beat entered during reciprocal run")

  // A flagged result carries a saturated coordinate.
  `BPT_ASSERT_IMP(a_ov_sat, c_vld && c_res.ov,
    (c_res.x == POS_MAX) || (c_res.x == NEG_MIN) || (c_res.y == POS_MAX) ||
    (c_res.y == NEG_MIN) || (c_res.z == POS_MAX) || (c_res.z == NEG_MIN),
    "overflow without saturated value")

endmodule
`default_nettype wire

/* dv/bubble_point_transform_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bubble point transform testbench
// Drives point beats through the stream ports, takes each expected result from
// a directed table or a behavioral Q16.16 bubble model, and compares every output beat
// field by field. The run walks several register settings, extremes included,
// with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module bubble_point_transform_test;
  import bpt_pkg::*;

  typedef struct packed {
    logic signed [31:0] acc_z;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] src_y;
    logic signed [31:0] src_x;
  } point_beat_t;

  typedef struct packed {
    logic        ov;
    logic [15:0] color;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } point_res_t;

  typedef struct packed {
    point_beat_t beat;
    logic        known;
    point_res_t  res;
  } dir_row_t;

  typedef struct packed {
    logic [23:0] weight;
    logic [23:0] center_x;
    logic [23:0] center_y;
    logic [23:0] scale;
  } setting_t;

  localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
  localparam logic [31:0] MINW = 32'h8000_0000;
  localparam int N_DIR    = 14;
  localparam int N_PHASES = 10;
  localparam int PER_PHASE = 170;
  localparam int HOLD_LEN = 300;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_idx = CFG_WEIGHT;
  logic [C_W-1:0]   cfg_data = '0;

  // Model copy of the registers and the reciprocal.
  logic signed [20:0] m_weight;
  logic signed [23:0] m_cx;
  logic signed [23:0] m_cy;
  longint             m_recip;

  point_res_t pending_q[$];
  int         fails = 0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;
  dir_row_t   dir_rows[N_DIR];
  setting_t   settings[N_PHASES];

  bubble_point_transform u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned absu(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // (a*b) >> s, rounded toward zero.
  function automatic longint scaled_product(input longint a, input longint b, input int s);
    longint unsigned p;
    p = (absu(a) * absu(b)) >> s;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clamp32(input longint v, inout bit ov);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      ov = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      ov = 1'b1;
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  function automatic longint recip_of(input logic signed [23:0] s);
    longint unsigned q;
    longint sv;
    sv = s;
    if (sv == 0) return 64'sh7FFF_FFFF;
    q = (64'd1 << 32) / absu(sv);
    if (sv > 0) return (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
    return (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
  endfunction

  // Expected result beat for one input beat under the current registers.
  function automatic point_res_t bubble_predict(input point_beat_t b);
    longint x, y, w, k, nx, ny, nz, ex, ey;
    longint unsigned r, den, kmag, sum, prod;
    bit ov;
    point_res_t res;
    ov = 1'b0;
    x = b.src_x;
    y = b.src_y;
    w = m_weight;
    r = absu(x) * absu(x) + absu(y) * absu(y);
    den = r + (64'd1 << 34);
    kmag = (absu(w) << 42) / den;
    k = (w < 0) ? -longint'(kmag) : longint'(kmag);
    nx = clamp32(2 * longint'(b.acc_x) + scaled_product(k, x, 24), ov);
    ny = clamp32(2 * longint'(b.acc_y) + scaled_product(k, y, 24), ov);
    nz = clamp32(2 * longint'(b.acc_z) + longint'(r >> 17) + 131072 - w, ov);
    ex = nx + longint'(m_cx);
    ey = ny + longint'(m_cy);
    sum = absu(ex) * absu(ex) + absu(ey) * absu(ey);
    prod = absu(m_recip) * sum;
    res.x = nx[31:0];
    res.y = ny[31:0];
    res.z = nz[31:0];
    res.color = prod[47:32];
    res.ov = ov;
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    if (sel < 85) return $urandom;
    case ($urandom_range(4))
      0: return MAXW;
      1: return MINW;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WEIGHT:   m_weight = val[20:0];
      CFG_CENTER_X: m_cx = val;
      CFG_CENTER_Y: m_cy = val;
      default:      m_recip = recip_of(val);
    endcase
  endtask

  // Registers change only once the pipeline has fully drained.
  task automatic apply_setting(input setting_t s);
    while (pending_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    write_reg(CFG_WEIGHT, s.weight);
    write_reg(CFG_CENTER_X, s.center_x);
    write_reg(CFG_CENTER_Y, s.center_y);
    write_reg(CFG_SCALE, s.scale);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one beat, idling first at random, and log its expectation on accept.
  task automatic send_beat(input point_beat_t b, input bit known, input point_res_t res);
    while (!calm && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    pending_q.push_back(known ? res : bubble_predict(b));
    @(negedge clk);
  endtask

  task automatic send_random();
    point_beat_t b;
    b.src_x = rand_word();
    b.src_y = rand_word();
    b.acc_x = rand_word();
    b.acc_y = rand_word();
    b.acc_z = rand_word();
    send_beat(b, 1'b0, '0);
  endtask

  initial begin
    dir_rows = '{
      '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b0, 16'h0, 32'h1_0000, 32'h0, 32'h0}},
      '{'{32'h0, 32'h0, MAXW, 32'h0, 32'h0}, 1'b1, '{1'b1, 16'h0, 32'h1_0000, 32'h0, MAXW}},
      '{'{32'h0, 32'h0, MINW, 32'h0, 32'h0}, 1'b1, '{1'b1, 16'h0, 32'h1_0000, 32'h0, MINW}},
      '{'{32'h0, MAXW, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b1, 16'h0, 32'h1_0000, MAXW, 32'h0}},
      '{'{MAXW, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b1, 16'h0, MAXW, 32'h0, 32'h0}},
      '{'{MINW, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b1, 16'h0, MINW, 32'h0, 32'h0}},
      '{'{32'h0, 32'h0, 32'h0, 32'h0, MAXW}, 1'b0, '0},
      '{'{32'h0, 32'h0, 32'h0, 32'h0, MINW}, 1'b0, '0},
      '{'{32'h0, 32'h0, 32'h0, MAXW, MAXW}, 1'b0, '0},
      '{'{MAXW, MAXW, MAXW, MAXW, MAXW}, 1'b0, '0},
      '{'{MINW, MINW, MINW, MINW, MINW}, 1'b0, '0},
      '{'{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000}, 1'b0, '0},
      '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0},
      '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '0}
    };
    // Zero weight and scale, then range extremes, reciprocal edges and random settings.
    settings[0] = '{24'h0, 24'h0, 24'h0, 24'h0};
    settings[1] = '{24'h08_0000, 24'h40_0000, 24'h40_0000, 24'h40_0000};
    settings[2] = '{24'hF8_0000, 24'hC0_0000, 24'hC0_0000, 24'hC0_0000};
    settings[3] = '{24'h0F_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'h00_0001};
    settings[4] = '{24'h10_0000, 24'h80_0000, 24'h7F_FFFF, 24'hFF_FFFF};
    settings[5] = '{24'h01_0000, 24'h00_8000, 24'hFF_8000, 24'h00_0002};
    settings[6] = '{24'hFF_0000, 24'h00_0000, 24'h00_0000, 24'hFF_FFFE};
    for (int i = 7; i < N_PHASES; i++) begin
      settings[i] = {$urandom, $urandom, $urandom};
    end
  end

  // Stimulus and phase sequencing.
  initial begin
    m_weight = 21'sh1_0000;
    m_cx = '0;
    m_cy = '0;
    m_recip = 65536;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < N_DIR; i++) begin
      send_beat(dir_rows[i].beat, dir_rows[i].known, dir_rows[i].res);
    end
    for (int p = 0; p < N_PHASES; p++) begin
      in_tvalid <= 1'b0;
      apply_setting(settings[p]);
      calm = (p == 2);
      if (p == 4) hold_req = 1'b1;
      for (int i = 0; i < PER_PHASE; i++) send_random();
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
    for (int t = 0; pending_q.size() != 0; t++) begin
      if (t > 20000) begin
        $display("FAIL");
        $finish;
      end
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Output side: random back-pressure, one long hold-off, and checking.
  initial begin
    int hold_left;
    point_res_t got;
    point_res_t want;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 25);
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = out_tdata[112:0];
        if (pending_q.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          want = pending_q.pop_front();
          if (got.x !== want.x) begin
            $error("out_x expected %h got %h", want.x, got.x);
            fails++;
          end
          if (got.y !== want.y) begin
            $error("out_y expected %h got %h", want.y, got.y);
            fails++;
          end
          if (got.z !== want.z) begin
            $error("out_z expected %h got %h", want.z, got.z);
            fails++;
          end
          if (got.color !== want.color) begin
            $error("color expected %h got %h", want.color, got.color);
            fails++;
          end
          if (got.ov !== want.ov) begin
            $error("overflow expected %b got %b", want.ov, got.ov);
            fails++;
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
